FILE: rtl/ffra_pkg.sv
package ffra_pkg;

    // Payload widths of the request and result channels
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 2;

    // Map words: the used map is stored 32 flags to a memory word
    localparam int WORD_W      = 32;
    localparam int WORD_BITS_W = 5;

    // Lowest block that may be handed out (blocks 0 and 1 are reserved)
    localparam int FIRST_USABLE = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;

endpackage

FILE: rtl/ffra_if.sv
// Request channel: one run allocation per transaction
interface ffra_req_if
    import ffra_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] req_size;

    modport source (output valid, output req_size, input ready);
    modport sink   (input valid, input req_size, output ready);
endinterface

// Result channel: status and start block of the run
interface ffra_res_if
    import ffra_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   start_block;

    modport source (output valid, output status, output start_block, input ready);
    modport sink   (input valid, input status, input start_block, output ready);
endinterface

FILE: rtl/ffra_ram.sv
module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/first_fit_run_allocator.sv
// First-fit run allocator. Each request transaction asks for req_size contiguous
// blocks; the block answers with one result transaction (status, start_block).
// The used map lives in a RAM of 32-flag words and is scanned one word per cycle
// from block 2 upward. A request is taken in the idle state. The scan reads map
// words in order until a free run is found or the last word has been read; a
// run that is found is then marked word by word (not for a size of 0), and the
// result is posted. A no-space answer scans all ENTRIES/32 words, rounded up. An
// oversized request goes straight to posting. Posting waits while the output
// register still holds a result that has not been taken.
// Blocks 0, 1 and ENTRIES-1 are never handed out. A size of 0 returns the lowest
// free block without marking it. After reset the map RAM is cleared one word a
// cycle and no request is taken until all words are cleared.
// The next request is taken once the previous one is finished, even if its
// result is still waiting in the output register.
module first_fit_run_allocator
    import ffra_pkg::*;
#(
    parameter int ENTRIES = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    ffra_req_if.sink   req,
    ffra_res_if.source res
);

    localparam int WORDS = (ENTRIES + WORD_W - 1) / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = WAW + 1;
    localparam int GW    = WAW + WORD_BITS_W;
    localparam int RW    = GW + 1;

    localparam logic [GW-1:0]  LAST_USABLE = GW'(ENTRIES - 2);
    localparam logic [GW-1:0]  FIRST_IDX   = GW'(FIRST_USABLE);
    localparam logic [IW-1:0]  WORDS_CNT   = IW'(WORDS);
    localparam logic [WAW-1:0] LAST_WORD   = WAW'(WORDS - 1);

    // Controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       issue_reg, issue_next;
    logic                rvld_reg, rvld_next;
    logic [WAW-1:0]      rword_reg, rword_next;
    logic [RW-1:0]       run_reg, run_next;
    logic [RW-1:0]       need_reg, need_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [GW-1:0]       start_reg, start_next;
    logic [STATUS_W-1:0] rstat_reg, rstat_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SIZE_W-1:0]   out_start_reg, out_start_next;

    logic                ram_we;
    logic [WAW-1:0]      ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    // Word evaluation results
    logic [WORD_W-1:0]   free_bits;
    logic [RW-1:0]       run_at [WORD_W];
    logic                any_hit;
    logic [RW-1:0]       hit_start;
    logic [RW-1:0]       run_end;

    // Mark range
    logic [GW-1:0]       end_idx;
    logic [WAW-1:0]      first_word;
    logic [WAW-1:0]      last_word;
    logic [WORD_W-1:0]   mark_mask;

    ffra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg[WAW-1:0]),
        .rdata (ram_rdata)
    );

    // Free runs inside the word just read; out-of-range blocks count as used
    always_comb
    begin : word_eval
        logic [GW-1:0]          base;
        logic [GW-1:0]          idx;
        logic                   has_used;
        logic [WORD_BITS_W-1:0] last_used;
        logic [RW-1:0]          hit_run;
        logic [WORD_BITS_W-1:0] hit_pos;
        base      = {rword_reg, {WORD_BITS_W{1'b0}}};
        has_used  = 1'b0;
        last_used = '0;
        any_hit   = 1'b0;
        hit_pos   = '0;
        hit_run   = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            idx          = base + GW'(b);
            free_bits[b] = !ram_rdata[b] && (idx >= FIRST_IDX) && (idx <= LAST_USABLE);
        end
        for (int b = 0; b < WORD_W; b++)
        begin
            if (!free_bits[b])
            begin
                has_used  = 1'b1;
                last_used = WORD_BITS_W'(b);
            end
            run_at[b] = has_used ? RW'(WORD_BITS_W'(b) - last_used)
                                 : run_reg + RW'(b) + RW'(1);
        end
        // lowest bit where the run reaches the request
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (free_bits[b] && (run_at[b] >= need_reg))
            begin
                any_hit = 1'b1;
                hit_pos = WORD_BITS_W'(b);
                hit_run = run_at[b];
            end
        end
        hit_start = RW'(base) + RW'(hit_pos) + RW'(1) - hit_run;
        run_end   = run_at[WORD_W-1];
    end

    // Word mask of the run being marked
    always_comb
    begin : mark_eval
        logic [WORD_BITS_W-1:0] lo;
        logic [WORD_BITS_W-1:0] hi;
        end_idx    = start_reg + GW'(size_reg) - GW'(1);
        first_word = start_reg[GW-1:WORD_BITS_W];
        last_word  = end_idx[GW-1:WORD_BITS_W];
        lo = (rword_reg == first_word) ? start_reg[WORD_BITS_W-1:0] : '0;
        hi = (rword_reg == last_word) ? end_idx[WORD_BITS_W-1:0] : '1;
        for (int i = 0; i < WORD_W; i++)
        begin
            mark_mask[i] = (WORD_BITS_W'(i) >= lo) && (WORD_BITS_W'(i) <= hi);
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.start_block = out_start_reg;

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        rvld_next       = 1'b0;
        rword_next      = rword_reg;
        run_next        = run_reg;
        need_next       = need_reg;
        size_next       = size_reg;
        start_next      = start_reg;
        rstat_next      = rstat_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        ram_we          = 1'b0;
        ram_waddr       = rword_reg;
        ram_wdata       = ram_rdata | mark_mask;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = issue_reg[WAW-1:0];
                ram_wdata  = '0;
                issue_next = issue_reg + IW'(1);
                if (issue_reg[WAW-1:0] == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    size_next = req.req_size;
                    if (32'(req.req_size) > 32'(ENTRIES - 2))
                    begin
                        rstat_next = ST_TOO_LARGE;
                        start_next = '0;
                        state_next = S_POST;
                    end
                    else
                    begin
                        need_next  = (req.req_size == '0) ? RW'(1) : RW'(req.req_size);
                        run_next   = '0;
                        issue_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // keep one word read in flight
                if (issue_reg < WORDS_CNT)
                begin
                    issue_next = issue_reg + IW'(1);
                    rvld_next  = 1'b1;
                    rword_next = issue_reg[WAW-1:0];
                end
                if (rvld_reg)
                begin
                    if (any_hit)
                    begin
                        start_next = GW'(hit_start);
                        rstat_next = ST_OK;
                        rvld_next  = 1'b0;
                        if (size_reg != '0)
                        begin
                            issue_next = IW'(hit_start[RW-1:WORD_BITS_W]);
                            state_next = S_MARK;
                        end
                        else
                        begin
                            state_next = S_POST;
                        end
                    end
                    else if (rword_reg == LAST_WORD)
                    begin
                        rstat_next = ST_NO_SPACE;
                        start_next = '0;
                        rvld_next  = 1'b0;
                        state_next = S_POST;
                    end
                    else
                    begin
                        run_next = run_end;
                    end
                end
            end

            S_MARK:
            begin
                // read word k while word k-1 is written back
                if (issue_reg <= {1'b0, last_word})
                begin
                    issue_next = issue_reg + IW'(1);
                    rvld_next  = 1'b1;
                    rword_next = issue_reg[WAW-1:0];
                end
                if (rvld_reg)
                begin
                    ram_we = 1'b1;
                    if (rword_reg == last_word)
                    begin
                        rvld_next  = 1'b0;
                        state_next = S_POST;
                    end
                end
            end

            S_POST:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rstat_reg;
                    out_start_next  = SIZE_W'(start_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            issue_reg     <= '0;
            rvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            rvld_reg      <= rvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rword_reg      <= rword_next;
        run_reg        <= run_next;
        need_reg       <= need_next;
        size_reg       <= size_next;
        start_reg      <= start_next;
        rstat_reg      <= rstat_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

endmodule
